[hdl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on aclk, suspended while aresetn is low.
`define PSET_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on aclk, also during reset.
`define PSET_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hdl/pset_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pset_pkg
// Types and codes shared by the prefix entry table modules.
// ----------------------------------------------------------------------------
package pset_pkg;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;
    localparam logic [1:0] ACT_FIND   = 2'd3;

    localparam logic REG_PREFIX_UPPER  = 1'b0;
    localparam logic REG_PREFIX_LENGTH = 1'b1;

    localparam logic [5:0] PREFIX_LENGTH_RESET = 6'd56;

    // One table entry; for the result, valid carries the hit flag.
    typedef struct packed {
        logic        valid;
        logic [63:0] addr_upper;
        logic [63:0] addr_lower;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [63:0] time_sec;
        logic [29:0] time_nsec;
    } entry_t;

    typedef enum logic [1:0] {
        RES_FLAG,
        RES_ENTRY,
        RES_MISS
    } res_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     exec;
        logic     clr_wr;
        logic     ptr_zero;
        logic     ptr_inc;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       entry_hit;
        logic       older;
        logic       ptr_last;
        logic       clr_last;
    } status_t;

endpackage

[hdl/pset_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pset_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pset_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/pset_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pset_ctrl
// Sequencer for clear pass, single-entry actions and the find-older scan.
// ----------------------------------------------------------------------------
module pset_ctrl
    import pset_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_EXEC  = 6'b000100,
        ST_LOOK  = 6'b001000,
        ST_SCAN  = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = RES_MISS;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr  = 1'b1;
                cmd.ptr_inc = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec     = 1'b1;
                cmd.ptr_zero = 1'b1;
                unique case (status.action)
                    ACT_ADD, ACT_REMOVE: begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_FLAG;
                        state_next   = ST_FIN;
                    end
                    ACT_LOOKUP: state_next = ST_LOOK;
                    default:    state_next = ST_SCAN;
                endcase
            end
            ST_LOOK: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = status.entry_hit ? RES_ENTRY : RES_MISS;
                state_next   = ST_FIN;
            end
            ST_SCAN: begin
                priority if (status.older) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_ENTRY;
                    state_next   = ST_FIN;
                end else if (status.ptr_last) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_MISS;
                    state_next   = ST_FIN;
                end else begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_FIN: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[hdl/pset_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pset_dp
// Datapath: configuration, input latch, prefix match, entry RAM, result.
// ----------------------------------------------------------------------------
module pset_dp
    import pset_pkg::*;
#(
    parameter int INDEX_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic [1:0]  s_action,
    input  logic [63:0] s_addr_upper,
    input  logic [63:0] s_addr_lower,
    input  logic [63:0] s_key_word0,
    input  logic [63:0] s_key_word1,
    input  logic [63:0] s_key_word2,
    input  logic [63:0] s_key_word3,
    input  logic [63:0] s_time_sec,
    input  logic [29:0] s_time_nsec,
    input  cmd_t        cmd,
    output status_t     status,
    output entry_t      out_entry
);

    localparam int         DEPTH   = 2 ** INDEX_BITS;
    localparam logic [5:0] MIN_LEN = 6'(64 - INDEX_BITS);

    logic [63:0] prefix_upper_reg;
    logic [5:0]  prefix_length_reg;
    logic [1:0]  act_reg;
    entry_t      in_reg;
    entry_t      res_reg, res_next;
    entry_t      out_reg;
    logic [INDEX_BITS-1:0] ptr_reg, ptr_next;

    logic [5:0]  eff_len;
    logic [6:0]  ib;
    logic [63:0] pmask;
    logic        in_prefix;
    logic [INDEX_BITS-1:0] idx, last_idx;

    logic                  ram_we;
    logic [INDEX_BITS-1:0] ram_waddr, ram_raddr;
    entry_t                ram_wdata, ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_upper_reg  <= '0;
            prefix_length_reg <= PREFIX_LENGTH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PREFIX_UPPER:  prefix_upper_reg  <= cfg_data;
                REG_PREFIX_LENGTH: prefix_length_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            act_reg <= s_action;
            in_reg  <= '{1'b1, s_addr_upper, s_addr_lower, s_key_word0, s_key_word1,
                         s_key_word2, s_key_word3, s_time_sec, s_time_nsec};
        end
    end

    // saturate the prefix length so the index never exceeds the table
    assign eff_len   = (prefix_length_reg < MIN_LEN) ? MIN_LEN : prefix_length_reg;
    assign ib        = 7'd64 - {1'b0, eff_len};
    assign pmask     = {64{1'b1}} << ib;
    assign in_prefix = ((in_reg.addr_upper ^ prefix_upper_reg) & pmask) == 64'd0;
    assign last_idx  = ~pmask[INDEX_BITS-1:0];
    assign idx       = in_reg.addr_upper[INDEX_BITS-1:0] & last_idx;

    always_comb begin
        ram_we    = cmd.clr_wr;
        ram_waddr = ptr_reg;
        ram_wdata = '0;
        if (cmd.exec && in_prefix && (act_reg == ACT_ADD || act_reg == ACT_REMOVE)) begin
            ram_we    = 1'b1;
            ram_waddr = idx;
            ram_wdata = (act_reg == ACT_ADD) ? in_reg : '0;
        end
        if (cmd.exec) begin
            ram_raddr = (act_reg == ACT_FIND) ? '0 : idx;
        end else begin
            ram_raddr = ptr_reg + 1'b1;
        end
    end

    pset_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.ptr_zero) begin
            ptr_next = '0;
        end else if (cmd.ptr_inc) begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else begin
            ptr_reg <= ptr_next;
        end
    end

    always_comb begin
        res_next = '0;
        unique case (cmd.res_sel)
            RES_FLAG:  res_next.valid = in_prefix;
            RES_ENTRY: res_next = ram_rdata;
            default:   res_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_reg <= res_next;
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign status.action    = act_reg;
    assign status.entry_hit = in_prefix && ram_rdata.valid;
    assign status.older     = ram_rdata.valid &&
                              ((ram_rdata.time_sec < in_reg.time_sec) ||
                               (ram_rdata.time_sec == in_reg.time_sec &&
                                ram_rdata.time_nsec < in_reg.time_nsec));
    assign status.ptr_last  = (ptr_reg == last_idx);
    assign status.clr_last  = &ptr_reg;
    assign out_entry        = out_reg;

endmodule

[hdl/prefix_suffix_entry_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_suffix_entry_table
// Peer-entry table for one IPv6 prefix, indexed by the address bits below the
// prefix length. Add, remove, lookup and find-older over a single entry RAM.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    action, address, key, time
//  m_       out        m_valid / m_ready    hit, stored address, key, time
//  cfg_     in         cfg_valid/cfg_ready  register index, 64-bit data
//
// Add and remove pass the execute and finish states; lookup also passes a look
// state for the registered RAM read. Find-older reads the entries in turn up to
// the first match or the end of the prefix range: one RAM read per entry.
// After reset a clearing pass writes all 2^INDEX_BITS entries, one per cycle,
// before the first item is taken. A waiting result holds in the output
// register; the next item is accepted meanwhile and finishes once it drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prefix_suffix_entry_table
    import pset_pkg::*;
#(
    parameter int INDEX_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [63:0] s_addr_upper,
    input  logic [63:0] s_addr_lower,
    input  logic [63:0] s_key_word0,
    input  logic [63:0] s_key_word1,
    input  logic [63:0] s_key_word2,
    input  logic [63:0] s_key_word3,
    input  logic [63:0] s_time_sec,
    input  logic [29:0] s_time_nsec,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [63:0] m_out_addr_upper,
    output logic [63:0] m_out_addr_lower,
    output logic [63:0] m_out_key_word0,
    output logic [63:0] m_out_key_word1,
    output logic [63:0] m_out_key_word2,
    output logic [63:0] m_out_key_word3,
    output logic [63:0] m_out_time_sec,
    output logic [29:0] m_out_time_nsec
);

    cmd_t    cmd;
    status_t status;
    entry_t  out_entry;

    assign cfg_ready = 1'b1;

    pset_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pset_dp #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_action     (s_action),
        .s_addr_upper (s_addr_upper),
        .s_addr_lower (s_addr_lower),
        .s_key_word0  (s_key_word0),
        .s_key_word1  (s_key_word1),
        .s_key_word2  (s_key_word2),
        .s_key_word3  (s_key_word3),
        .s_time_sec   (s_time_sec),
        .s_time_nsec  (s_time_nsec),
        .cmd          (cmd),
        .status       (status),
        .out_entry    (out_entry)
    );

    assign m_hit            = out_entry.valid;
    assign m_out_addr_upper = out_entry.addr_upper;
    assign m_out_addr_lower = out_entry.addr_lower;
    assign m_out_key_word0  = out_entry.key_word0;
    assign m_out_key_word1  = out_entry.key_word1;
    assign m_out_key_word2  = out_entry.key_word2;
    assign m_out_key_word3  = out_entry.key_word3;
    assign m_out_time_sec   = out_entry.time_sec;
    assign m_out_time_nsec  = out_entry.time_nsec;

    `PSET_ASSERT(a_one_item_at_a_time, (s_valid && s_ready) |=> !s_ready, "second item taken while busy")
    `PSET_ASSERT(a_miss_is_zero, (m_valid && !m_hit) |-> (m_out_time_sec == 64'd0 && m_out_addr_upper == 64'd0), "miss result carries data")
    `PSET_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> (!m_valid && !s_ready), "output or input active after reset")

endmodule
